[hw/rtl/bmhq_pkg.sv]
// package with shared types and constants of the heap queue
`timescale 1ns / 1ps
`default_nettype none
package bmhq_pkg;
	localparam int unsigned CAPACITY_DEF = 256;
	localparam int unsigned KEY_W = 32;
	localparam int unsigned PAY_W = 32;
	localparam int unsigned ENTRY_W = KEY_W + PAY_W;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_FULL = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH_WR,
		S_UP_RD,
		S_UP_CMP,
		S_POP_RDLAST,
		S_POP_WRROOT,
		S_DN_RD,
		S_DN_CMP,
		S_RES_RD,
		S_RES_OUT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load_in;      // capture input item
		logic push_wr;      // write new entry at count+1 and bump count
		logic up_rd;        // read parent of cursor
		logic up_swap;      // write swap of cursor and parent
		logic rd_last;      // read last entry and root
		logic wr_root;      // move last entry to root, drop count
		logic dn_rd;        // read children of cursor
		logic dn_swap;      // write swap of cursor and chosen child
		logic rd_top;       // read root for result
		logic load_res;     // fill output register
		logic set_full;
		logic set_empty;
	} bmhq_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic is_pop;
		logic full;
		logic empty;
		logic at_root;      // cursor is 1
		logic up_go;        // parent key strictly greater
		logic has_child;    // 2*cursor <= count
		logic dn_go;        // cursor key strictly greater than chosen child
		logic out_busy;     // output register holds a result
	} bmhq_stat_t;
endpackage
`default_nettype wire

[hw/rtl/binary_min_heap_queue_unit.sv]
// top level of the binary min-heap priority queue
// Each transfer is a push or a pop on a min-heap of CAPACITY entries held in one
// dual-read RAM; one result is given per item. For each level that the entry moves
// there is one RAM read and a swap of two writes, as the heap RAM has a single
// write port. One item is worked at a time; the output register lets the next item
// in while a result waits. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module binary_min_heap_queue_unit #(
	parameter int unsigned CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic cmd,
	input wire logic [31:0] key,
	input wire logic [31:0] payload,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] status,
	output logic [31:0] popped_key,
	output logic [31:0] popped_payload,
	output logic top_valid,
	output logic [31:0] top_key,
	output logic [31:0] top_payload,
	output logic [$clog2(CAPACITY+1)-1:0] entry_count
);
	import bmhq_pkg::*;
	bmhq_cmd_t cmd_c;
	bmhq_stat_t stat;

	bmhq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.stat(stat), .cmd_c(cmd_c)
	);

	bmhq_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd_c(cmd_c), .stat(stat),
		.in_cmd(cmd), .in_key(key), .in_payload(payload),
		.out_take(!out_stall), .out_valid(out_valid), .status(status),
		.popped_key(popped_key), .popped_payload(popped_payload),
		.top_valid(top_valid), .top_key(top_key), .top_payload(top_payload),
		.entry_count(entry_count)
	);
endmodule
`default_nettype wire

[hw/rtl/bmhq_ram.sv]
// generic single write, dual read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module bmhq_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 256
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end
endmodule
`default_nettype wire

[hw/rtl/bmhq_datapath.sv]
// datapath: heap memory, count, cursor, compare and output register
`timescale 1ns / 1ps
`default_nettype none
module bmhq_datapath #(
	parameter int unsigned CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire bmhq_pkg::bmhq_cmd_t cmd_c,
	output bmhq_pkg::bmhq_stat_t stat,
	input wire logic in_cmd,
	input wire logic [31:0] in_key,
	input wire logic [31:0] in_payload,
	input wire logic out_take,
	output logic out_valid,
	output logic [1:0] status,
	output logic [31:0] popped_key,
	output logic [31:0] popped_payload,
	output logic top_valid,
	output logic [31:0] top_key,
	output logic [31:0] top_payload,
	output logic [$clog2(CAPACITY+1)-1:0] entry_count
);
	import bmhq_pkg::*;
	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	// positions are 1-based, one bit wider than the count so that 2*pos+1 fits
	localparam int unsigned PW = CW + 1;

	logic cmd_q;
	logic [ENTRY_W-1:0] new_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] other_q;
	logic [ENTRY_W-1:0] cur_q;
	logic [ENTRY_W-1:0] popped_q;
	logic [1:0] stat_q;

	logic we;
	logic [AW-1:0] waddr;
	logic [ENTRY_W-1:0] wdata;
	logic [AW-1:0] ra, rb;
	logic [ENTRY_W-1:0] da, db;
	logic [PW-1:0] cnt_p, child_l, child_r, parent;
	logic pick_r;
	logic [ENTRY_W-1:0] child_e;
	logic swap_second;

	bmhq_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr_a(ra), .raddr_b(rb), .rdata_a(da), .rdata_b(db)
	);

	assign cnt_p = PW'(count_q);
	assign parent = pos_q >> 1;
	assign child_l = pos_q << 1;
	assign child_r = child_l + PW'(1);

	// choose the smaller child, left on a tie
	assign pick_r = (child_r <= cnt_p) && (da[ENTRY_W-1 -: KEY_W] > db[ENTRY_W-1 -: KEY_W]);
	assign child_e = pick_r ? db : da;

	// read addresses
	always_comb begin
		ra = '0;
		rb = '0;
		if (cmd_c.up_rd) begin
			ra = AW'(parent - PW'(1));
		end else if (cmd_c.rd_last) begin
			ra = AW'(cnt_p - PW'(1));
		end else if (cmd_c.dn_rd) begin
			ra = AW'(child_l - PW'(1));
			rb = AW'(child_r - PW'(1));
		end else if (cmd_c.rd_top) begin
			ra = '0;
		end
	end

	// write port: a swap is written in two writes, cursor side first
	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = cur_q;
		if (cmd_c.push_wr) begin
			we = 1'b1;
			waddr = AW'(cnt_p);
			wdata = new_q;
		end else if (cmd_c.up_swap) begin
			we = 1'b1;
			waddr = swap_second ? AW'(parent - PW'(1)) : AW'(pos_q - PW'(1));
			wdata = swap_second ? cur_q : da;
		end else if (cmd_c.wr_root) begin
			we = 1'b1;
			waddr = '0;
			wdata = da;
		end else if (cmd_c.dn_swap) begin
			we = 1'b1;
			waddr = swap_second ? AW'(other_q - PW'(1)) : AW'(pos_q - PW'(1));
			wdata = swap_second ? cur_q : child_e;
		end
	end

	assign stat.is_pop = cmd_q;
	assign stat.full = (count_q == CW'(CAPACITY));
	assign stat.empty = (count_q == '0);
	assign stat.at_root = (pos_q == PW'(1));
	assign stat.up_go = (da[ENTRY_W-1 -: KEY_W] > cur_q[ENTRY_W-1 -: KEY_W]);
	assign stat.has_child = (child_l <= cnt_p);
	assign stat.dn_go = (cur_q[ENTRY_W-1 -: KEY_W] > child_e[ENTRY_W-1 -: KEY_W]);
	assign stat.out_busy = out_valid;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid <= 1'b0;
			swap_second <= 1'b0;
		end else begin
			if (cmd_c.push_wr) count_q <= count_q + CW'(1);
			if (cmd_c.wr_root) count_q <= count_q - CW'(1);
			if (cmd_c.up_swap || cmd_c.dn_swap) swap_second <= !swap_second;
			if (cmd_c.load_res) out_valid <= 1'b1;
			else if (out_take) out_valid <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_c.load_in) begin
			cmd_q <= in_cmd;
			new_q <= {in_key, in_payload};
			popped_q <= '0;
			stat_q <= ST_DONE;
		end
		if (cmd_c.set_full) stat_q <= ST_FULL;
		if (cmd_c.set_empty) stat_q <= ST_EMPTY;
		if (cmd_c.push_wr) begin
			pos_q <= cnt_p + PW'(1);
			cur_q <= new_q;
		end
		if (cmd_c.up_swap && swap_second) pos_q <= parent;
		// root read with the last entry is the popped entry
		if (cmd_c.wr_root) begin
			pos_q <= PW'(1);
			cur_q <= da;
			popped_q <= db;
		end
		if (cmd_c.dn_swap && !swap_second) other_q <= pick_r ? child_r : child_l;
		if (cmd_c.dn_swap && swap_second) pos_q <= other_q;
		if (cmd_c.load_res) begin
			status <= stat_q;
			popped_key <= popped_q[ENTRY_W-1 -: KEY_W];
			popped_payload <= popped_q[PAY_W-1:0];
			top_valid <= (count_q != '0);
			top_key <= (count_q != '0) ? da[ENTRY_W-1 -: KEY_W] : '0;
			top_payload <= (count_q != '0) ? da[PAY_W-1:0] : '0;
			entry_count <= count_q;
		end
	end
endmodule
`default_nettype wire

[hw/rtl/bmhq_ctrl.sv]
// controller state machine of the heap queue
`timescale 1ns / 1ps
`default_nettype none
module bmhq_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire bmhq_pkg::bmhq_stat_t stat,
	output bmhq_pkg::bmhq_cmd_t cmd_c
);
	import bmhq_pkg::*;
	state_t state_q, state_d;
	logic half_q;

	// state register and swap phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			half_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_c.up_swap || cmd_c.dn_swap) half_q <= !half_q;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd_c = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd_c.load_in = 1'b1;
					state_d = S_PUSH_WR;
				end
			end
			S_PUSH_WR: begin
				if (!stat.is_pop) begin
					if (stat.full) begin
						cmd_c.set_full = 1'b1;
						state_d = S_RES_RD;
					end else begin
						cmd_c.push_wr = 1'b1;
						state_d = S_UP_RD;
					end
				end else if (stat.empty) begin
					cmd_c.set_empty = 1'b1;
					state_d = S_RES_RD;
				end else begin
					cmd_c.rd_last = 1'b1;
					state_d = S_POP_WRROOT;
				end
			end
			S_UP_RD: begin
				if (stat.at_root) state_d = S_RES_RD;
				else begin
					cmd_c.up_rd = 1'b1;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (half_q || stat.up_go) begin
					cmd_c.up_swap = 1'b1;
					state_d = half_q ? S_UP_RD : S_UP_CMP;
				end else state_d = S_RES_RD;
			end
			S_POP_WRROOT: begin
				cmd_c.wr_root = 1'b1;
				state_d = S_DN_RD;
			end
			S_DN_RD: begin
				if (!stat.has_child) state_d = S_RES_RD;
				else begin
					cmd_c.dn_rd = 1'b1;
					state_d = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				if (half_q || stat.dn_go) begin
					cmd_c.dn_swap = 1'b1;
					state_d = half_q ? S_DN_RD : S_DN_CMP;
				end else state_d = S_RES_RD;
			end
			S_RES_RD: begin
				cmd_c.rd_top = 1'b1;
				state_d = S_RES_OUT;
			end
			S_RES_OUT: begin
				if (!stat.out_busy) begin
					cmd_c.load_res = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

[hw/rtl/bmhq_checker.sv]
// port-level checker of the heap queue and its bind
`timescale 1ns / 1ps
`default_nettype none
module bmhq_checker #(
	parameter int unsigned CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [1:0] status,
	input wire logic top_valid,
	input wire logic [31:0] top_key,
	input wire logic [$clog2(CAPACITY+1)-1:0] entry_count
);
	import bmhq_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_count))
		else $error("stalled result changed");

	// top valid follows the count
	a_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> top_valid == (entry_count != '0))
		else $error("top_valid disagrees with count");

	// an empty heap shows a zero top key
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !top_valid |-> top_key == '0)
		else $error("empty heap with nonzero top");

	// count never exceeds capacity and status is a known code
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= ($clog2(CAPACITY+1))'(CAPACITY) &&
		(status == ST_DONE || status == ST_FULL || status == ST_EMPTY))
		else $error("result out of range");
endmodule

bind binary_min_heap_queue_unit bmhq_checker #(.CAPACITY(CAPACITY)) u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.status(status), .top_valid(top_valid), .top_key(top_key),
	.entry_count(entry_count)
);
`default_nettype wire
